// ----- sv/trimmed_mean_ph_bang_bang_core_macros.svh -----
// assertion helpers used by the checker file
`ifndef TRIMMED_MEAN_PH_BANG_BANG_CORE_MACROS_SVH
`define TRIMMED_MEAN_PH_BANG_BANG_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define TMPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define TMPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tmph_pkg.sv -----
package tmph_pkg;

    localparam int ADC_W       = 10;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 17;
    localparam int PH_W        = 17;
    localparam int TARGET_W    = 16;
    localparam int TOL_W       = 16;
    localparam int SUM_W       = 24;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [PH_W-1:0]     ph_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [TARGET_W-1:0]        target_t;
    typedef logic [TOL_W-1:0]           tol_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN,
        REG_OFFSET,
        REG_SETPOINT,
        REG_TOLERANCE
    } cfg_reg_t;

    localparam gain_t   GAIN_RESET   = 24'sd1193804;
    localparam offset_t OFFSET_RESET = 17'sd3113;
    localparam target_t TARGET_RESET = 16'd0;
    localparam tol_t    TOL_RESET    = 16'd1638;

    localparam ph_t PH_MIN = {1'b1, {(PH_W-1){1'b0}}};
    localparam ph_t PH_MAX = {1'b0, {(PH_W-1){1'b1}}};

endpackage

// ----- sv/trimmed_mean_ph_bang_bang_core.sv -----
// trimmed-mean pH bang-bang core: takes one raw 10-bit probe reading per request
// and turns it into pH in 1/4096 units, ph = round(gain * adc / 2^16) + offset,
// saturated to a signed 17-bit value. Over each window of WINDOW requests it
// keeps a running sum, minimum and maximum; the last request of a window yields
// one result: the average without one smallest and one largest sample (rounded
// half up) and a pump decision. acid runs when the average is above
// setpoint + tolerance, alkali when below setpoint - tolerance; a setpoint
// of zero keeps both off. Other requests give no result. One request is taken
// every cycle; a window's last request goes through the conversion pipeline
// (input, product, pH), the divider (biased numerator, reciprocal product) and
// the result register to m_valid. The input only stalls when the result register
// is held by m_ready and the stages behind it are full. Registers are written
// through cfg_we / cfg_index / cfg_wdata (0 gain, 1 offset, 2 setpoint,
// 3 tolerance) by the user only while idle; the core does not enforce this.
module trimmed_mean_ph_bang_bang_core #(
    parameter int WINDOW = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // sample requests
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tmph_pkg::ADC_W-1:0]           s_adc_sample,
    // window results
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tmph_pkg::ph_t                        m_avg_ph,
    output logic                                 m_acid_pump,
    output logic                                 m_alkali_pump,
    // register writes
    input  logic                                 cfg_we,
    input  logic [tmph_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tmph_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import tmph_pkg::*;

    localparam int CNT_W = $clog2(WINDOW);
    localparam int CMP_W = PH_W + 2;

    // configuration registers
    gain_t   gain_reg;
    offset_t offset_reg;
    target_t target_reg;
    tol_t    tol_reg;

    // window state
    logic [CNT_W-1:0] count_reg;
    sum_t             sum_reg;
    ph_t              min_reg;
    ph_t              max_reg;
    sum_t             sum_next;
    ph_t              min_next;
    ph_t              max_next;

    // result register
    logic             m_valid_reg;
    ph_t              avg_reg;
    logic             acid_reg;
    logic             alkali_reg;
    logic             acid_next;
    logic             alkali_next;

    // stage links
    logic             conv_valid;
    logic             conv_ready;
    ph_t              conv_ph;
    logic             div_in_valid;
    logic             div_in_ready;
    logic             div_valid;
    logic             div_ready;
    ph_t              div_avg;

    logic             first_sample;
    logic             last_sample;
    logic             conv_take;
    logic             div_take;

    logic signed [CMP_W-1:0] avg_cmp;
    logic signed [CMP_W-1:0] hi_cmp;
    logic signed [CMP_W-1:0] lo_cmp;

    // register writes, indexes outside the list do nothing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
            target_reg <= TARGET_RESET;
            tol_reg    <= TOL_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN: begin
                    gain_reg <= cfg_wdata[GAIN_W-1:0];
                end
                REG_OFFSET: begin
                    offset_reg <= cfg_wdata[OFFSET_W-1:0];
                end
                REG_SETPOINT: begin
                    target_reg <= cfg_wdata[TARGET_W-1:0];
                end
                REG_TOLERANCE: begin
                    tol_reg <= cfg_wdata[TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // adc count to pH, three registered stages
    tmph_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_adc    (s_adc_sample),
        .gain      (gain_reg),
        .offset    (offset_reg),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_ph    (conv_ph)
    );

    // running sum / min / max; the closing sample of a window needs room
    // in the divider, every other sample is absorbed right away
    assign first_sample = (count_reg == '0);
    assign last_sample  = (count_reg == CNT_W'(WINDOW - 1));
    assign conv_ready   = !last_sample || div_in_ready;
    assign conv_take    = conv_valid && conv_ready;
    assign div_in_valid = conv_valid && last_sample;

    always_comb begin
        if (first_sample) begin
            sum_next = SUM_W'(conv_ph);
            min_next = conv_ph;
            max_next = conv_ph;
        end else begin
            sum_next = sum_reg + SUM_W'(conv_ph);
            min_next = (conv_ph < min_reg) ? conv_ph : min_reg;
            max_next = (conv_ph > max_reg) ? conv_ph : max_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (conv_take) begin
            count_reg <= last_sample ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_take) begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // trimmed average, the window totals ride along with the request
    tmph_divide #(
        .WINDOW (WINDOW)
    ) u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_in_valid),
        .in_ready  (div_in_ready),
        .in_sum    (sum_next),
        .in_min    (min_next),
        .in_max    (max_next),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_avg   (div_avg)
    );

    // bang-bang decision against target +/- tolerance
    assign div_ready = !m_valid_reg || m_ready;
    assign div_take  = div_valid && div_ready;

    always_comb begin
        avg_cmp     = CMP_W'(div_avg);
        hi_cmp      = $signed(CMP_W'(target_reg)) + $signed(CMP_W'(tol_reg));
        lo_cmp      = $signed(CMP_W'(target_reg)) - $signed(CMP_W'(tol_reg));
        acid_next   = 1'b0;
        alkali_next = 1'b0;
        if (target_reg != '0) begin
            if (avg_cmp > hi_cmp) begin
                acid_next = 1'b1;
            end else if (avg_cmp < lo_cmp) begin
                alkali_next = 1'b1;
            end
        end
    end

    // pumps hold the last decision between windows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            acid_reg    <= 1'b0;
            alkali_reg  <= 1'b0;
        end else begin
            if (div_ready) begin
                m_valid_reg <= div_valid;
            end
            if (div_take) begin
                acid_reg   <= acid_next;
                alkali_reg <= alkali_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_take) begin
            avg_reg <= div_avg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_avg_ph      = avg_reg;
    assign m_acid_pump   = acid_reg;
    assign m_alkali_pump = alkali_reg;

endmodule

// ----- sv/tmph_convert.sv -----
module tmph_convert (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmph_pkg::ADC_W-1:0]    in_adc,
    input  tmph_pkg::gain_t               gain,
    input  tmph_pkg::offset_t             offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tmph_pkg::ph_t                 out_ph
);
    import tmph_pkg::*;

    localparam int PROD_W   = GAIN_W + ADC_W;
    localparam int ROUND_W  = PROD_W - FRAC_W;
    localparam int PHSUM_W  = ROUND_W + 1;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(2 ** (FRAC_W - 1));

    logic                      adc_valid_reg;
    logic [ADC_W-1:0]          adc_reg;
    logic                      prod_valid_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic                      ph_valid_reg;
    ph_t                       ph_reg;
    ph_t                       ph_next;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [PHSUM_W-1:0] ph_wide;
    logic                      adc_free;
    logic                      prod_free;
    logic                      ph_free;

    // stall chain, back to front
    assign ph_free   = !ph_valid_reg || out_ready;
    assign prod_free = !prod_valid_reg || ph_free;
    assign adc_free  = !adc_valid_reg || prod_free;
    assign in_ready  = adc_free;

    assign prod_next = PROD_W'(gain) * PROD_W'($signed({1'b0, adc_reg}));

    // round half up, drop the fraction, add the intercept, clamp
    always_comb begin
        rounded = prod_reg + HALF_LSB;
        ph_wide = PHSUM_W'($signed(rounded[PROD_W-1:FRAC_W])) + PHSUM_W'(offset);
        if (ph_wide < PHSUM_W'(PH_MIN)) begin
            ph_next = PH_MIN;
        end else if (ph_wide > PHSUM_W'(PH_MAX)) begin
            ph_next = PH_MAX;
        end else begin
            ph_next = PH_W'(ph_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            ph_valid_reg   <= 1'b0;
        end else begin
            if (adc_free) begin
                adc_valid_reg <= in_valid;
            end
            if (prod_free) begin
                prod_valid_reg <= adc_valid_reg;
            end
            if (ph_free) begin
                ph_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adc_free) begin
            adc_reg <= in_adc;
        end
        if (prod_free) begin
            prod_reg <= prod_next;
        end
        if (ph_free) begin
            ph_reg <= ph_next;
        end
    end

    assign out_valid = ph_valid_reg;
    assign out_ph    = ph_reg;

endmodule

// ----- sv/tmph_divide.sv -----
module tmph_divide #(
    parameter int WINDOW = 10
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tmph_pkg::sum_t in_sum,
    input  tmph_pkg::ph_t  in_min,
    input  tmph_pkg::ph_t  in_max,
    output logic           out_valid,
    input  logic           out_ready,
    output tmph_pkg::ph_t  out_avg
);
    import tmph_pkg::*;

    // avg = floor((2*num + DEN) / (2*DEN)), the numerator biased positive by DIV * 2^PH_W
    // so that an exact unsigned reciprocal multiply can do the division
    localparam int DEN    = WINDOW - 2;
    localparam int DIV    = 2 * DEN;
    localparam int DIV_W  = $clog2(DIV);
    localparam int U_W    = DIV_W + PH_W + 1;
    localparam int SHIFT  = U_W + DIV_W;
    localparam int R_W    = U_W + 2;
    localparam int P_W    = U_W + R_W;
    localparam int CALC_W = SUM_W + 8;
    localparam logic [R_W-1:0] RECIP =
        R_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic signed [CALC_W-1:0] U_BIAS = CALC_W'(64'(DIV) << PH_W);

    logic                      u_valid_reg;
    logic [U_W-1:0]            u_reg;
    logic [U_W-1:0]            u_next;
    logic                      prod_valid_reg;
    logic [P_W-1:0]            prod_reg;
    logic signed [CALC_W-1:0]  num;
    logic signed [CALC_W-1:0]  u_calc;
    logic                      u_free;
    logic                      prod_free;

    assign prod_free = !prod_valid_reg || out_ready;
    assign u_free    = !u_valid_reg || prod_free;
    assign in_ready  = u_free;

    always_comb begin
        num    = CALC_W'(in_sum) - CALC_W'(in_min) - CALC_W'(in_max);
        u_calc = (num <<< 1) + CALC_W'(DEN) + U_BIAS;
        u_next = u_calc[U_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_valid_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (u_free) begin
                u_valid_reg <= in_valid;
            end
            if (prod_free) begin
                prod_valid_reg <= u_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (u_free) begin
            u_reg <= u_next;
        end
        if (prod_free) begin
            prod_reg <= P_W'(u_reg) * P_W'(RECIP);
        end
    end

    // quotient minus the 2^PH_W bias is just its low PH_W bits
    assign out_valid = prod_valid_reg;
    assign out_avg   = $signed(prod_reg[SHIFT +: PH_W]);

endmodule

// ----- sv/tmph_checker.sv -----
`include "trimmed_mean_ph_bang_bang_core_macros.svh"

module tmph_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input tmph_pkg::ph_t m_avg_ph,
    input logic          m_acid_pump,
    input logic          m_alkali_pump
);
    import tmph_pkg::*;

    logic [PH_W+1:0] result_word;
    logic [1:0]      pumps;
    logic            in_stalled;
    logic            out_stalled;

    assign result_word = {m_avg_ph, m_acid_pump, m_alkali_pump};
    assign pumps       = {m_acid_pump, m_alkali_pump};
    assign in_stalled  = s_valid && !s_ready;
    assign out_stalled = m_valid && !m_ready;

    // a held result keeps its payload
    `TMPH_ASSERT_NEXT(a_result_held, out_stalled, m_valid && $stable(result_word), "result moved")

    // never both pumps at once
    `TMPH_ASSERT_NOW(a_pumps_exclusive, 1'b1, !(m_acid_pump && m_alkali_pump), "both pumps on")

    // pump outputs only move together with a new result
    `TMPH_ASSERT_NOW(a_pumps_follow, !$stable(pumps), m_valid, "pumps changed without a result")

    // input back-pressure only comes from a stalled result
    `TMPH_ASSERT_NOW(a_stall_from_output, in_stalled, out_stalled, "input held while output free")

endmodule

bind trimmed_mean_ph_bang_bang_core tmph_checker u_tmph_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_avg_ph      (m_avg_ph),
    .m_acid_pump   (m_acid_pump),
    .m_alkali_pump (m_alkali_pump)
);

// ----- tb/trimmed_mean_ph_bang_bang_core_test.sv -----
module trimmed_mean_ph_bang_bang_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tmph_pkg::*;

    // one window result: trimmed average and the pump decision taken with it
    typedef struct packed {
        ph_t  avg_ph;
        logic acid;
        logic alkali;
    } window_result_t;

    // tracks the converted samples of the open window, predicts each window result
    // and checks the results coming out of the core in order
    class ph_window_checker;
        int window_len;

        // register copies
        gain_t   gain;
        offset_t offset;
        target_t target;
        tol_t    tolerance;

        // open window
        int     fill;
        longint window_sum;
        longint window_min;
        longint window_max;

        window_result_t pending_windows[$];

        int samples_taken;
        int windows_checked;
        int acid_seen;
        int alkali_seen;
        int off_seen;
        int mismatches;

        function new(int len);
            window_len = len;
            gain       = GAIN_RESET;
            offset     = OFFSET_RESET;
            target     = TARGET_RESET;
            tolerance  = TOL_RESET;
            fill       = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN:      gain      = gain_t'(data);
                REG_OFFSET:    offset    = offset_t'(data[OFFSET_W-1:0]);
                REG_SETPOINT:  target    = data[TARGET_W-1:0];
                REG_TOLERANCE: tolerance = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function ph_t clamp_ph(longint v);
            if (v < longint'(PH_MIN)) return PH_MIN;
            if (v > longint'(PH_MAX)) return PH_MAX;
            return ph_t'(v);
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        // probe reading to pH, product rounded half up before the offset
        function ph_t ph_of(gain_t g, offset_t o, logic [ADC_W-1:0] adc);
            longint v;
            v = ((longint'(g) * longint'(adc) + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W)
                + longint'(o);
            return clamp_ph(v);
        endfunction

        function void take_sample(logic [ADC_W-1:0] adc);
            ph_t            p;
            longint         num;
            longint         hi;
            longint         lo;
            window_result_t r;
            p = ph_of(gain, offset, adc);
            samples_taken++;
            if (fill == 0) begin
                window_sum = p;
                window_min = p;
                window_max = p;
            end else begin
                window_sum += p;
                if (p < window_min) window_min = p;
                if (p > window_max) window_max = p;
            end
            fill++;
            if (fill < window_len) return;
            fill = 0;

            // drop one smallest and one largest, average rounded half up
            num = window_sum - window_min - window_max;
            r.avg_ph = clamp_ph(floor_div(2 * num + (window_len - 2),
                                          2 * (window_len - 2)));
            r.acid   = 1'b0;
            r.alkali = 1'b0;
            if (target != 0) begin
                hi = longint'(target) + longint'(tolerance);
                lo = longint'(target) - longint'(tolerance);
                if (longint'(r.avg_ph) > hi) r.acid = 1'b1;
                else if (longint'(r.avg_ph) < lo) r.alkali = 1'b1;
            end
            pending_windows.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_window(ph_t avg_ph, logic acid, logic alkali);
            window_result_t e;
            if (pending_windows.size() == 0) begin
                note_mismatch($sformatf("unexpected result avg_ph %0d acid %0b alkali %0b",
                                        avg_ph, acid, alkali));
                return;
            end
            e = pending_windows.pop_front();
            if (avg_ph !== e.avg_ph || acid !== e.acid || alkali !== e.alkali)
                note_mismatch($sformatf({"window %0d: expected avg_ph %0d acid %0b alkali %0b,",
                                         " got avg_ph %0d acid %0b alkali %0b"},
                                        windows_checked, e.avg_ph, e.acid, e.alkali,
                                        avg_ph, acid, alkali));
            windows_checked++;
            if (e.acid) acid_seen++;
            else if (e.alkali) alkali_seen++;
            else off_seen++;
        endfunction
    endclass

    localparam int WINDOW         = 10;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int N_ITEMS        = 950;
    localparam int IDLE_PCT       = 6;
    // lets the core drain, with margin, before registers are touched
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_SETTING  = 3;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // sample request side
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [ADC_W-1:0]     s_adc_sample = '0;

    // window result side
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    ph_t                  m_avg_ph;
    logic                 m_acid_pump;
    logic                 m_alkali_pump;

    // register port
    logic                 cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = REG_GAIN;
    logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

    ph_window_checker tracker = new(WINDOW);

    int samples_sent;
    int settings_applied;
    int stall_cycles;
    bit steady;          // no random idling on either side while set
    bit stall_request;   // asks the result side for one long hold-off
    int hold_left;

    // first window: reading extremes and alternating bit patterns
    logic [ADC_W-1:0] first_window [10] = '{0, 1023, 341, 682, 1, 1022, 512, 511, 0, 1023};

    trimmed_mean_ph_bang_bang_core #(
        .WINDOW        (WINDOW)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_sample  (s_adc_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_ph      (m_avg_ph),
        .m_acid_pump   (m_acid_pump),
        .m_alkali_pump (m_alkali_pump),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // offer one request and hold it until the core takes it
    task automatic send_sample(input logic [ADC_W-1:0] adc);
        s_valid      <= 1'b1;
        s_adc_sample <= adc;
        do @(posedge aclk); while (!s_ready);
        tracker.take_sample(adc);
        samples_sent++;
    endtask

    // random one-cycle gaps between requests
    task automatic pace();
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // stop offering, let every pending window come out, then let the
    // conversion pipeline run dry so register writes hit an idle core
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        tracker.set_reg(idx, data);
    endtask

    task automatic apply_setting(input gain_t g, input offset_t o,
                                 input target_t t, input tol_t tl);
        load_reg(REG_GAIN,      CFG_DATA_W'(g));
        load_reg(REG_OFFSET,    CFG_DATA_W'(o));
        load_reg(REG_SETPOINT,  CFG_DATA_W'(t));
        load_reg(REG_TOLERANCE, CFG_DATA_W'(tl));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // result side: check every accepted result, random back-pressure,
    // plus one long hold-off on request to fill the core up
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_window(m_avg_ph, m_acid_pump, m_alkali_pump);
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = HOLD_CYCLES;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: too long without any handshake means the core is stuck
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", stall_cycles);
            $display("[trimmed_mean_ph_bang_bang_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int      setting_no;
        int      n;
        int      center;
        int      spread;
        int      c;
        longint  tc;
        gain_t   g;
        offset_t o;
        target_t t;
        tol_t    tl;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting, zero target keeps both pumps off
        foreach (first_window[i]) begin
            send_sample(first_window[i]);
            pace();
        end

        // half-way products round up: gain 0.5 per count
        wait_idle();
        apply_setting(gain_t'(32768), offset_t'(0), target_t'(1), tol_t'(0));
        repeat (3) send_sample(10'd1);
        // negative halves round toward +inf too (mid-window gain change)
        wait_idle();
        apply_setting(gain_t'(-32768), offset_t'(-1), target_t'(1), tol_t'(0));
        send_sample(10'd1);
        send_sample(10'd3);
        // saturation at the top, tied maxima
        wait_idle();
        apply_setting(gain_t'(PH_MAX) | 24'h7FFFFF, offset_t'(PH_MAX),
                      target_t'(16'hFFFF), tol_t'(16'hFFFF));
        send_sample(10'd1023);
        send_sample(10'd0);
        // saturation at the bottom, tied minima; average lands exactly on
        // target - tolerance so both pumps stay off
        wait_idle();
        apply_setting(gain_t'(24'h800000), offset_t'(PH_MIN), target_t'(1), tol_t'(8193));
        send_sample(10'd1023);
        send_sample(10'd1);
        send_sample(10'd0);
        // flat pH from a zero gain, leaves a partial window open
        wait_idle();
        apply_setting(gain_t'(0), offset_t'(5000), target_t'(4001), tol_t'(999));
        repeat (5) send_sample(10'($urandom_range(1023)));

        // random settings, each with a burst of readings around some level
        setting_no = 0;
        while (samples_sent < N_ITEMS) begin
            setting_no++;
            wait_idle();

            case ($urandom_range(5))
                0, 1:    g = gain_t'(1193804 + int'($urandom_range(400000)) - 200000);
                2:       g = gain_t'($urandom());
                3:       g = gain_t'(int'($urandom_range(131072)) - 65536);
                4:       g = $urandom_range(1) ? gain_t'(24'h7FFFFF) : gain_t'(24'h800000);
                default: g = gain_t'(-(1193804 + int'($urandom_range(400000)) - 200000));
            endcase
            case ($urandom_range(3))
                0:       o = offset_t'(3113 + int'($urandom_range(4000)) - 2000);
                1:       o = offset_t'($urandom());
                2:       o = $urandom_range(1) ? PH_MAX : PH_MIN;
                default: o = '0;
            endcase

            center = $urandom_range(1023);
            case ($urandom_range(3))
                0:       spread = 0;
                1:       spread = 3;
                2:       spread = 40;
                default: spread = 1023;
            endcase

            // target near the expected level so all three decisions show up
            case ($urandom_range(4))
                0: t = '0;
                1: t = target_t'($urandom());
                default: begin
                    tc = longint'(tracker.ph_of(g, o, 10'(center)))
                         + int'($urandom_range(6000)) - 3000;
                    if (tc < 1) tc = 1;
                    if (tc > 65535) tc = 65535;
                    t = target_t'(tc);
                end
            endcase
            case ($urandom_range(3))
                0:       tl = '0;
                1:       tl = 16'hFFFF;
                default: tl = tol_t'($urandom_range(2500));
            endcase
            apply_setting(g, o, t, tl);

            // one long burst with no gaps while the result side holds off
            if (setting_no == STALL_SETTING) begin
                steady        = 1'b1;
                stall_request = 1'b1;
                n             = 200;
            end else begin
                n = $urandom_range(15, 90);
            end
            if (n > N_ITEMS - samples_sent) n = N_ITEMS - samples_sent;

            for (int k = 0; k < n; k++) begin
                if ($urandom_range(19) == 0) c = $urandom_range(1) ? 1023 : 0;
                else if (spread == 1023) c = $urandom_range(1023);
                else c = center + int'($urandom_range(2 * spread)) - spread;
                if (c < 0) c = 0;
                if (c > 1023) c = 1023;
                send_sample(10'(c));
                pace();
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d readings, %0d windows, %0d register settings, %0d-cycle hold",
                 tracker.samples_taken, tracker.windows_checked, settings_applied, HOLD_CYCLES);
        $display("decisions: acid %0d, alkali %0d, off %0d; mismatches %0d",
                 tracker.acid_seen, tracker.alkali_seen, tracker.off_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_windows.size() == 0) begin
            $display("[trimmed_mean_ph_bang_bang_core] OK");
        end else begin
            $display("[trimmed_mean_ph_bang_bang_core] ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/tmph_pkg.sv
sv/tmph_convert.sv
sv/tmph_divide.sv
sv/trimmed_mean_ph_bang_bang_core.sv
sv/tmph_checker.sv
tb/trimmed_mean_ph_bang_bang_core_test.sv
